// ===== sv/segtxt_pkg.sv =====
// Shared types, constants and segment table for the seven-segment text renderer.
package segtxt_pkg;

    // Sizing of the stored number and of the largest drawn segment
    localparam int MAX_DIGITS = 8;
    localparam int MAX_SCALE  = 15;

    // Field widths of the request and result channels
    localparam int VALUE_W = 27;
    localparam int SCALE_W = 4;
    localparam int GLYPH_W = 2;

    // Decimal conversion: shift-and-add-3, a few steps per pipeline stage
    localparam int DIGIT_W         = 4;
    localparam int BCD_W           = MAX_DIGITS * DIGIT_W;
    localparam int STEPS_PER_STAGE = 4;
    localparam int SHIFT_W         = ((VALUE_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE)
                                     * STEPS_PER_STAGE;
    localparam int CONV_STAGES     = SHIFT_W / STEPS_PER_STAGE;

    // Frame counters
    localparam int POS_W    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int TOTAL_W  = $clog2(MAX_DIGITS + 1);
    localparam int HSCALE_W = $clog2(MAX_SCALE + 1);
    localparam int CELL_W   = $clog2(MAX_SCALE + 3);
    localparam int LINE_W   = $clog2(2 * MAX_SCALE + 4);

    // Request modes
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    typedef enum logic [GLYPH_W-1:0] {
        GLYPH_SPACE   = 2'd0,
        GLYPH_DASH    = 2'd1,
        GLYPH_BAR     = 2'd2,
        GLYPH_NEWLINE = 2'd3
    } glyph_t;

    // Bit positions in a segment mask
    typedef enum logic [2:0] {
        SEG_TOP         = 3'd0,
        SEG_UPPER_LEFT  = 3'd1,
        SEG_UPPER_RIGHT = 3'd2,
        SEG_MIDDLE      = 3'd3,
        SEG_LOWER_LEFT  = 3'd4,
        SEG_LOWER_RIGHT = 3'd5,
        SEG_BOTTOM      = 3'd6
    } seg_t;

    // One request as it travels down the conversion pipeline
    typedef struct packed {
        logic                mode;
        logic [SCALE_W-1:0]  scale;
        logic [SHIFT_W-1:0]  bin;
        logic [BCD_W-1:0]    bcd;
    } item_t;

    // Lit segments of a decimal digit; codes above nine light nothing
    function automatic logic [6:0] seg_mask(input logic [DIGIT_W-1:0] digit);
        logic [6:0] mask;
        case (digit)
            4'd0:    mask = 7'h77;
            4'd1:    mask = 7'h24;
            4'd2:    mask = 7'h5D;
            4'd3:    mask = 7'h6D;
            4'd4:    mask = 7'h2E;
            4'd5:    mask = 7'h6B;
            4'd6:    mask = 7'h7B;
            4'd7:    mask = 7'h25;
            4'd8:    mask = 7'h7F;
            4'd9:    mask = 7'h6F;
            default: mask = 7'h00;
        endcase
        return mask;
    endfunction

endpackage

// ===== sv/segtxt_bcd_stage.sv =====
// One pipeline stage of the binary to decimal conversion (a few shift-and-add-3 steps).
module segtxt_bcd_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  segtxt_pkg::item_t   in_item,
    output logic                out_valid,
    output segtxt_pkg::item_t   out_item
);

    logic              valid_reg;
    segtxt_pkg::item_t item_reg;
    segtxt_pkg::item_t item_next;

    // Run the conversion steps; digits above the kept count shift out and drop
    always_comb begin
        logic [segtxt_pkg::BCD_W-1:0]   b;
        logic [segtxt_pkg::SHIFT_W-1:0] r;
        b = in_item.bcd;
        r = in_item.bin;
        for (int s = 0; s < segtxt_pkg::STEPS_PER_STAGE; s++) begin
            for (int d = 0; d < segtxt_pkg::MAX_DIGITS; d++) begin
                if (b[d*segtxt_pkg::DIGIT_W +: segtxt_pkg::DIGIT_W] >= 4'd5) begin
                    b[d*segtxt_pkg::DIGIT_W +: segtxt_pkg::DIGIT_W] =
                        b[d*segtxt_pkg::DIGIT_W +: segtxt_pkg::DIGIT_W] + 4'd3;
                end
            end
            b = {b[segtxt_pkg::BCD_W-2:0], r[segtxt_pkg::SHIFT_W-1]};
            r = {r[segtxt_pkg::SHIFT_W-2:0], 1'b0};
        end
        item_next       = in_item;
        item_next.bcd   = b;
        item_next.bin   = r;
    end

    // Hold the stage while the pipeline is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== sv/segtxt_render.sv =====
// Frame state, glyph selection and result register of the renderer.
module segtxt_render (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  segtxt_pkg::item_t   in_item,
    output logic                out_valid,
    output segtxt_pkg::glyph_t  out_glyph,
    output logic                out_eol,
    output logic                out_eof
);

    // Frame state
    logic [segtxt_pkg::BCD_W-1:0]    digit_store_reg, digit_store_next;
    logic [segtxt_pkg::TOTAL_W-1:0]  digit_total_reg, digit_total_next;
    logic [segtxt_pkg::HSCALE_W-1:0] scale_held_reg, scale_held_next;
    logic [segtxt_pkg::LINE_W-1:0]   line_index_reg, line_index_next;
    logic [segtxt_pkg::POS_W-1:0]    digit_pos_reg, digit_pos_next;
    logic [segtxt_pkg::CELL_W-1:0]   cell_pos_reg, cell_pos_next;
    logic                            active_reg, active_next;

    // Result register
    logic                            out_valid_reg, out_valid_next;
    segtxt_pkg::glyph_t              glyph_reg, glyph_next;
    logic                            eol_reg, eol_next;
    logic                            eof_reg, eof_next;

    // Frame geometry from the held scale
    logic [segtxt_pkg::LINE_W-1:0]   s_line, mid_line, bot_line, end_line;
    logic [segtxt_pkg::CELL_W-1:0]   side_cell, wrap_cell;
    logic [segtxt_pkg::POS_W-1:0]    rd_idx;
    logic [segtxt_pkg::DIGIT_W-1:0]  digit_rd;
    logic [6:0]                      mask;
    segtxt_pkg::seg_t                seg_sel;
    segtxt_pkg::glyph_t              cell_glyph;
    logic                            at_side;
    logic [segtxt_pkg::TOTAL_W-1:0]  load_count;
    logic [segtxt_pkg::HSCALE_W-1:0] load_scale;

    assign s_line    = segtxt_pkg::LINE_W'(scale_held_reg);
    assign mid_line  = s_line + segtxt_pkg::LINE_W'(1);
    assign bot_line  = (s_line << 1) + segtxt_pkg::LINE_W'(2);
    assign end_line  = bot_line + segtxt_pkg::LINE_W'(1);
    assign side_cell = segtxt_pkg::CELL_W'(scale_held_reg) + segtxt_pkg::CELL_W'(1);
    assign wrap_cell = segtxt_pkg::CELL_W'(scale_held_reg) + segtxt_pkg::CELL_W'(2);

    // Digits sit least significant first; count positions from the leading one
    assign rd_idx   = segtxt_pkg::POS_W'(digit_total_reg - segtxt_pkg::TOTAL_W'(1))
                      - digit_pos_reg;
    assign digit_rd = digit_store_reg[rd_idx*segtxt_pkg::DIGIT_W +: segtxt_pkg::DIGIT_W];
    assign mask     = segtxt_pkg::seg_mask(digit_rd);
    assign at_side  = (cell_pos_reg == '0) || (cell_pos_reg == side_cell);

    // Pick the character inside a digit cell
    always_comb begin
        seg_sel    = segtxt_pkg::SEG_TOP;
        cell_glyph = segtxt_pkg::GLYPH_SPACE;
        if (line_index_reg == '0 || line_index_reg == mid_line
                || line_index_reg == bot_line) begin
            if (line_index_reg == '0) begin
                seg_sel = segtxt_pkg::SEG_TOP;
            end else if (line_index_reg == mid_line) begin
                seg_sel = segtxt_pkg::SEG_MIDDLE;
            end else begin
                seg_sel = segtxt_pkg::SEG_BOTTOM;
            end
            if (!at_side && mask[seg_sel]) begin
                cell_glyph = segtxt_pkg::GLYPH_DASH;
            end
        end else begin
            if (cell_pos_reg == '0) begin
                seg_sel = (line_index_reg <= s_line) ? segtxt_pkg::SEG_UPPER_LEFT
                                                     : segtxt_pkg::SEG_LOWER_LEFT;
                if (mask[seg_sel]) begin
                    cell_glyph = segtxt_pkg::GLYPH_BAR;
                end
            end else if (cell_pos_reg == side_cell) begin
                seg_sel = (line_index_reg <= s_line) ? segtxt_pkg::SEG_UPPER_RIGHT
                                                     : segtxt_pkg::SEG_LOWER_RIGHT;
                if (mask[seg_sel]) begin
                    cell_glyph = segtxt_pkg::GLYPH_BAR;
                end
            end
        end
    end

    // Count kept digits (leading zeros dropped, zero keeps one) and clamp the scale
    always_comb begin
        load_count = segtxt_pkg::TOTAL_W'(1);
        for (int k = 0; k < segtxt_pkg::MAX_DIGITS; k++) begin
            if (in_item.bcd[k*segtxt_pkg::DIGIT_W +: segtxt_pkg::DIGIT_W] != '0) begin
                load_count = segtxt_pkg::TOTAL_W'(k + 1);
            end
        end
        if (32'(in_item.scale) > 32'(segtxt_pkg::MAX_SCALE)) begin
            load_scale = segtxt_pkg::HSCALE_W'(segtxt_pkg::MAX_SCALE);
        end else begin
            load_scale = segtxt_pkg::HSCALE_W'(in_item.scale);
        end
    end

    // Step the frame for one request
    always_comb begin
        digit_store_next = digit_store_reg;
        digit_total_next = digit_total_reg;
        scale_held_next  = scale_held_reg;
        line_index_next  = line_index_reg;
        digit_pos_next   = digit_pos_reg;
        cell_pos_next    = cell_pos_reg;
        active_next      = active_reg;
        out_valid_next   = 1'b0;
        glyph_next       = segtxt_pkg::GLYPH_SPACE;
        eol_next         = 1'b0;
        eof_next         = 1'b0;
        if (in_valid) begin
            if (in_item.mode == segtxt_pkg::MODE_LOAD) begin
                digit_store_next = in_item.bcd;
                digit_total_next = load_count;
                scale_held_next  = load_scale;
                line_index_next  = '0;
                digit_pos_next   = '0;
                cell_pos_next    = '0;
                active_next      = 1'b1;
            end else if (active_reg) begin
                out_valid_next = 1'b1;
                if (line_index_reg >= end_line) begin
                    // Empty last line: close the frame
                    glyph_next      = segtxt_pkg::GLYPH_NEWLINE;
                    eol_next        = 1'b1;
                    eof_next        = 1'b1;
                    active_next     = 1'b0;
                    line_index_next = '0;
                    digit_pos_next  = '0;
                    cell_pos_next   = '0;
                end else if (cell_pos_reg >= wrap_cell) begin
                    if (segtxt_pkg::TOTAL_W'(digit_pos_reg) + segtxt_pkg::TOTAL_W'(1)
                            >= digit_total_reg) begin
                        glyph_next      = segtxt_pkg::GLYPH_NEWLINE;
                        eol_next        = 1'b1;
                        line_index_next = line_index_reg + segtxt_pkg::LINE_W'(1);
                        digit_pos_next  = '0;
                    end else begin
                        glyph_next     = segtxt_pkg::GLYPH_SPACE;
                        digit_pos_next = digit_pos_reg + segtxt_pkg::POS_W'(1);
                    end
                    cell_pos_next = '0;
                end else begin
                    glyph_next    = cell_glyph;
                    cell_pos_next = cell_pos_reg + segtxt_pkg::CELL_W'(1);
                end
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_total_reg <= '0;
            scale_held_reg  <= '0;
            line_index_reg  <= '0;
            digit_pos_reg   <= '0;
            cell_pos_reg    <= '0;
            active_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else if (adv) begin
            digit_total_reg <= digit_total_next;
            scale_held_reg  <= scale_held_next;
            line_index_reg  <= line_index_next;
            digit_pos_reg   <= digit_pos_next;
            cell_pos_reg    <= cell_pos_next;
            active_reg      <= active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Digits and result payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            digit_store_reg <= digit_store_next;
            glyph_reg       <= glyph_next;
            eol_reg         <= eol_next;
            eof_reg         <= eof_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_glyph = glyph_reg;
    assign out_eol   = eol_reg;
    assign out_eof   = eof_reg;

`ifndef ASSERT_OFF
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (segtxt_pkg::TOTAL_W'(digit_pos_reg) < digit_total_reg))
        else $error("digit position beyond stored digits");

    a_cell_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (cell_pos_reg <= wrap_cell))
        else $error("cell position past the cell separator");

    a_line_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (line_index_reg <= end_line))
        else $error("line index past the last line");

    a_eof_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && eof_reg) |-> !active_reg)
        else $error("frame still active after its final newline");
`endif

endmodule

// ===== sv/scaled_seven_segment_text_renderer_core.sv =====
// Top level of the scaled seven-segment text renderer.
//
// Usage: a request on the s_ channel either loads a number and a scale
// (s_mode = 0) or asks for the next character of the drawing (s_mode = 1).
// Each advance during an active frame gives one result on the m_ channel:
// a glyph code (space, dash, bar, newline) with end-of-line and end-of-frame
// flags. Loads, and advances with no frame active, give no result. A load
// in the middle of a frame restarts the drawing with the new number.
//
// Timing: requests flow through a 7-stage decimal conversion pipeline
// (four shift-and-add-3 steps per stage) and then the frame stage, which
// writes the result register. One request is taken every cycle unless
// the output stalls.
// Stall: while a result waits with m_ready low, the whole pipeline holds and
// s_ready is low; nothing is lost or repeated.
// Reset (aresetn low, synchronous): the pipeline empties and no frame is
// active until the next load.
module scaled_seven_segment_text_renderer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_mode,
    input  logic [segtxt_pkg::VALUE_W-1:0]  s_value,
    input  logic [segtxt_pkg::SCALE_W-1:0]  s_scale,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [segtxt_pkg::GLYPH_W-1:0]  m_glyph,
    output logic                            m_end_of_line,
    output logic                            m_end_of_frame
);

    logic [segtxt_pkg::CONV_STAGES:0] stage_valid;
    segtxt_pkg::item_t                stage_item [segtxt_pkg::CONV_STAGES+1];
    logic                             adv;
    segtxt_pkg::glyph_t               glyph;

    // Advance the whole pipeline unless a result is waiting
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Build the request entering the conversion
    assign stage_valid[0]      = s_valid;
    assign stage_item[0].mode  = s_mode;
    assign stage_item[0].scale = s_scale;
    assign stage_item[0].bin   = segtxt_pkg::SHIFT_W'(s_value);
    assign stage_item[0].bcd   = '0;

    for (genvar i = 0; i < segtxt_pkg::CONV_STAGES; i++) begin : g_conv
        segtxt_bcd_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (stage_valid[i]),
            .in_item   (stage_item[i]),
            .out_valid (stage_valid[i+1]),
            .out_item  (stage_item[i+1])
        );
    end

    segtxt_render u_render (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (stage_valid[segtxt_pkg::CONV_STAGES]),
        .in_item   (stage_item[segtxt_pkg::CONV_STAGES]),
        .out_valid (m_valid),
        .out_glyph (glyph),
        .out_eol   (m_end_of_line),
        .out_eof   (m_end_of_frame)
    );

    assign m_glyph = glyph;

`ifndef ASSERT_OFF
    a_eof_is_eol: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_frame) |-> m_end_of_line)
        else $error("end of frame without end of line");

    a_eol_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((glyph == segtxt_pkg::GLYPH_NEWLINE) == m_end_of_line))
        else $error("end of line flag disagrees with glyph");

    a_no_result_from_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(adv) && !$past(stage_valid[segtxt_pkg::CONV_STAGES]))
        |-> !m_valid)
        else $error("result produced with no request in the last stage");
`endif

endmodule

// ===== tb/sv/scaled_seven_segment_text_renderer_core_tb.sv =====
// Self-checking testbench for the scaled seven-segment text renderer core.
`timescale 1ns / 100ps

module scaled_seven_segment_text_renderer_core_tb;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_ITEMS    = 900;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 24;
    localparam int REPORT_LIMIT    = 20;

    // Lit segments per decimal digit, bit order as in seg_t
    localparam logic [6:0] DIGIT_SEGMENTS [16] = '{
        7'h77, 7'h24, 7'h5D, 7'h6D, 7'h2E, 7'h6B, 7'h7B, 7'h25, 7'h7F, 7'h6F,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    typedef struct {
        segtxt_pkg::glyph_t glyph;
        logic               end_of_line;
        logic               end_of_frame;
    } glyph_expect_t;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic                            s_mode;
    logic [segtxt_pkg::VALUE_W-1:0]  s_value;
    logic [segtxt_pkg::SCALE_W-1:0]  s_scale;
    logic                            m_valid;
    logic                            m_ready;
    logic [segtxt_pkg::GLYPH_W-1:0]  m_glyph;
    logic                            m_end_of_line;
    logic                            m_end_of_frame;

    // Renderer state as predicted
    logic [3:0]  rd_digits [segtxt_pkg::MAX_DIGITS];
    int          rd_count;
    int          rd_scale;
    int          rd_row;
    int          rd_digit;
    int          rd_col;
    bit          rd_active;

    glyph_expect_t glyph_queue [$];

    int  gap_pct;
    bit  hold_off_req;
    int  cycle_count;
    int  mismatches;
    int  loads_sent;
    int  advances_sent;
    int  effective_items;
    int  glyphs_checked;
    int  frames_done;

    scaled_seven_segment_text_renderer_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_value        (s_value),
        .s_scale        (s_scale),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_glyph        (m_glyph),
        .m_end_of_line  (m_end_of_line),
        .m_end_of_frame (m_end_of_frame)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Advance the predicted renderer by one request; return 1 when a glyph comes out
    function automatic bit render_step(input logic mode,
                                       input logic [segtxt_pkg::VALUE_W-1:0] value,
                                       input logic [segtxt_pkg::SCALE_W-1:0] scale,
                                       output glyph_expect_t res);
        int unsigned        v;
        int                 k;
        int                 count;
        int                 s;
        logic [3:0]         low_digits [segtxt_pkg::MAX_DIGITS];
        logic [6:0]         lit;
        segtxt_pkg::seg_t   seg;
        bit                 upper;
        res.glyph        = segtxt_pkg::GLYPH_SPACE;
        res.end_of_line  = 1'b0;
        res.end_of_frame = 1'b0;
        // Load: keep the low decimal digits, drop leading zeros, restart the frame
        if (mode == segtxt_pkg::MODE_LOAD) begin
            v = 32'(value);
            count = 1;
            for (k = 0; k < segtxt_pkg::MAX_DIGITS; k++) begin
                low_digits[k] = 4'(v % 10);
                v = v / 10;
                if (low_digits[k] != 0) count = k + 1;
            end
            for (k = 0; k < count; k++) rd_digits[k] = low_digits[count - 1 - k];
            rd_count  = count;
            rd_scale  = (scale > segtxt_pkg::MAX_SCALE) ? segtxt_pkg::MAX_SCALE : int'(scale);
            rd_row    = 0;
            rd_digit  = 0;
            rd_col    = 0;
            rd_active = 1'b1;
            return 1'b0;
        end
        if (!rd_active) return 1'b0;
        s = rd_scale;
        if (rd_row >= 2 * s + 3) begin
            // Empty closing line ends the frame
            res.glyph        = segtxt_pkg::GLYPH_NEWLINE;
            res.end_of_line  = 1'b1;
            res.end_of_frame = 1'b1;
            rd_active = 1'b0;
            rd_row    = 0;
            rd_digit  = 0;
            rd_col    = 0;
        end else if (rd_col >= s + 2) begin
            // Past the cell: separator, or newline after the last digit
            if (rd_digit + 1 >= rd_count) begin
                res.glyph       = segtxt_pkg::GLYPH_NEWLINE;
                res.end_of_line = 1'b1;
                rd_row++;
                rd_digit = 0;
            end else begin
                rd_digit++;
            end
            rd_col = 0;
        end else begin
            lit = DIGIT_SEGMENTS[rd_digits[rd_digit]];
            if (rd_row == 0 || rd_row == s + 1 || rd_row == 2 * s + 2) begin
                // Horizontal segment, corners stay blank
                if (rd_row == 0) seg = segtxt_pkg::SEG_TOP;
                else if (rd_row == s + 1) seg = segtxt_pkg::SEG_MIDDLE;
                else seg = segtxt_pkg::SEG_BOTTOM;
                if (rd_col != 0 && rd_col != s + 1 && lit[seg])
                    res.glyph = segtxt_pkg::GLYPH_DASH;
            end else begin
                // Vertical segments on the cell edges
                upper = (rd_row <= s);
                if (rd_col == 0) begin
                    seg = upper ? segtxt_pkg::SEG_UPPER_LEFT : segtxt_pkg::SEG_LOWER_LEFT;
                    if (lit[seg]) res.glyph = segtxt_pkg::GLYPH_BAR;
                end else if (rd_col == s + 1) begin
                    seg = upper ? segtxt_pkg::SEG_UPPER_RIGHT : segtxt_pkg::SEG_LOWER_RIGHT;
                    if (lit[seg]) res.glyph = segtxt_pkg::GLYPH_BAR;
                end
            end
            rd_col++;
        end
        return 1'b1;
    endfunction

    // Advances needed to finish the frame just loaded
    function automatic int frame_length();
        return (2 * rd_scale + 3) * rd_count * (rd_scale + 3) + 1;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) >= gap_pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Offer one request, hold it until accepted, then predict its glyph
    task automatic send_request(input logic mode,
                                input logic [segtxt_pkg::VALUE_W-1:0] value,
                                input logic [segtxt_pkg::SCALE_W-1:0] scale);
        int            gap;
        glyph_expect_t res;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_mode  = mode;
        s_value = value;
        s_scale = scale;
        do @(posedge aclk); while (!s_ready);
        if (render_step(mode, value, scale, res)) begin
            glyph_queue.push_back(res);
            effective_items++;
        end
        if (mode == segtxt_pkg::MODE_LOAD) begin
            loads_sent++;
            effective_items++;
        end else begin
            advances_sent++;
        end
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic load_number(input logic [segtxt_pkg::VALUE_W-1:0] value, input int scale);
        send_request(segtxt_pkg::MODE_LOAD, value, segtxt_pkg::SCALE_W'(scale));
    endtask

    // Advance requests carry random don't-care payload
    task automatic advance(input int count);
        repeat (count) send_request(segtxt_pkg::MODE_ADVANCE,
                                    segtxt_pkg::VALUE_W'($urandom),
                                    segtxt_pkg::SCALE_W'($urandom));
    endtask

    task automatic test_idle_advance();
        gap_pct = 0;
        advance(2);
    endtask

    task automatic test_zero_value();
        gap_pct = 20;
        load_number('0, 0);
        advance(frame_length() + 1);
    endtask

    task automatic test_value_extremes();
        gap_pct = 20;
        load_number(segtxt_pkg::VALUE_W'(99999999), 0);
        advance(frame_length());
        // Full field width wraps to the low eight digits; restart mid-frame
        load_number('1, 1);
        advance(40);
        load_number(segtxt_pkg::VALUE_W'(100000000), 1);
        advance(frame_length());
    endtask

    task automatic test_restart_midframe();
        gap_pct = 30;
        load_number(segtxt_pkg::VALUE_W'(88), 2);
        advance(7);
        load_number(segtxt_pkg::VALUE_W'(5), 3);
        load_number(segtxt_pkg::VALUE_W'(47), 1);
        advance(frame_length());
    endtask

    task automatic test_largest_scale();
        gap_pct = 10;
        load_number(segtxt_pkg::VALUE_W'(8), segtxt_pkg::MAX_SCALE);
        advance(frame_length());
        load_number(segtxt_pkg::VALUE_W'(88888888), segtxt_pkg::MAX_SCALE);
        advance(200);
        load_number(segtxt_pkg::VALUE_W'(1), 0);
        advance(frame_length());
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        gap_pct = 0;
        load_number(segtxt_pkg::VALUE_W'(5), 3);
        hold_off_req = 1'b1;
        advance(60);
    endtask

    // Mostly complete frames with random content; some cut short, some trailing noise
    task automatic test_random_frames();
        int                             start;
        int                             n;
        int                             k;
        int                             s;
        int                             r;
        int                             len;
        logic [segtxt_pkg::VALUE_W-1:0] value;
        start = effective_items;
        while (effective_items - start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 40;
            endcase
            r = $urandom_range(0, 99);
            if (r < 88) s = $urandom_range(0, 3);
            else if (r < 97) s = $urandom_range(4, 9);
            else s = $urandom_range(10, 15);
            if ($urandom_range(0, 99) < 3) begin
                value = segtxt_pkg::VALUE_W'($urandom);
                s = $urandom_range(0, 1);
            end else begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
                value = segtxt_pkg::VALUE_W'($urandom_range(n == 1 ? 0 : 1, 9));
                for (k = 1; k < n; k++)
                    value = segtxt_pkg::VALUE_W'(value * 10 + $urandom_range(0, 9));
                // Keep wide frames narrow
                if (s > 9) value = segtxt_pkg::VALUE_W'(value % 10);
                else if (s > 3) value = segtxt_pkg::VALUE_W'(value % 100);
            end
            load_number(value, s);
            len = frame_length();
            if ($urandom_range(0, 99) < 15) len = $urandom_range(0, len - 1);
            else if ($urandom_range(0, 3) == 0) len = len + $urandom_range(1, 3);
            advance(len);
        end
    endtask

    task automatic flag_mismatch(input string field, input logic [3:0] want,
                                 input logic [3:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            if (stall > 0) begin
                m_ready = 1'b0;
                stall--;
            end else begin
                stall = pick_gap();
                m_ready = (stall == 0);
                if (stall > 0) stall--;
            end
        end
    end

    // Compare each delivered glyph with the oldest prediction
    always @(posedge aclk) begin
        glyph_expect_t want;
        if (aresetn && m_valid && m_ready) begin
            if (glyph_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t ns: glyph %0d delivered with none expected", $time, m_glyph);
            end else begin
                want = glyph_queue.pop_front();
                if (m_glyph !== want.glyph)
                    flag_mismatch("glyph", 4'(want.glyph), 4'(m_glyph));
                if (m_end_of_line !== want.end_of_line)
                    flag_mismatch("end_of_line", 4'(want.end_of_line), 4'(m_end_of_line));
                if (m_end_of_frame !== want.end_of_frame)
                    flag_mismatch("end_of_frame", 4'(want.end_of_frame), 4'(m_end_of_frame));
                glyphs_checked++;
                if (want.end_of_frame) frames_done++;
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped at cycle limit %0d", CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_mode          = segtxt_pkg::MODE_ADVANCE;
        s_value         = '0;
        s_scale         = '0;
        gap_pct         = 0;
        hold_off_req    = 1'b0;
        cycle_count     = 0;
        mismatches      = 0;
        loads_sent      = 0;
        advances_sent   = 0;
        effective_items = 0;
        glyphs_checked  = 0;
        frames_done     = 0;
        rd_count        = 0;
        rd_scale        = 0;
        rd_row          = 0;
        rd_digit        = 0;
        rd_col          = 0;
        rd_active       = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_idle_advance();
        test_zero_value();
        test_value_extremes();
        test_restart_midframe();
        test_largest_scale();
        test_backpressure();
        test_random_frames();

        // Drain outstanding glyphs, then let the pipeline settle
        gap_pct = 0;
        while (glyph_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d loads and %0d advances, %0d glyphs checked in %0d whole frames,",
                 loads_sent, advances_sent, glyphs_checked, frames_done);
        $display("scales 0 to %0d, wrapped values, restarts and a %0d-cycle output hold-off.",
                 segtxt_pkg::MAX_SCALE, HOLD_OFF_CYCLES);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/segtxt_pkg.sv
sv/segtxt_bcd_stage.sv
sv/segtxt_render.sv
sv/scaled_seven_segment_text_renderer_core.sv
tb/sv/scaled_seven_segment_text_renderer_core_tb.sv
